/* src/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and saturation helpers for the Q24.8 arithmetic unit.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;

	typedef enum logic [3:0] {
		K_ADD      = 4'd0,
		K_SUB      = 4'd1,
		K_MUL      = 4'd2,
		K_DIV      = 4'd3,
		K_MIN      = 4'd4,
		K_MAX      = 4'd5,
		K_COMPARE  = 4'd6,
		K_INC      = 4'd7,
		K_DEC      = 4'd8,
		K_TO_INT   = 4'd9,
		K_FROM_INT = 4'd10
	} kind_t;

	typedef enum logic [1:0] {
		OP_SIMPLE = 2'd0,
		OP_MUL    = 2'd1,
		OP_DIV    = 2'd2
	} op_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		op_t         op;
		logic [31:0] result;
		logic        err;
		logic        less;
		logic        equal;
		logic        greater;
		logic        neg;
		logic        a_neg;
		logic        b_zero;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
	} item_t;

	typedef struct packed {
		logic [31:0] result;
		logic        less;
		logic        equal;
		logic        greater;
		logic        error;
	} res_t;

	// Clamp a signed 64-bit value to 32 bits; returns {err, value}.
	function automatic logic [32:0] clamp64(input logic signed [63:0] v);
		logic [32:0] r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r = {1'b1, INT_MAX};
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = {1'b1, INT_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	// Apply a sign to a magnitude and saturate; returns {err, value}.
	function automatic logic [32:0] sign_sat(input logic [63:0] mag, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				r = {1'b1, INT_MIN};
			end else begin
				r = {1'b0, 32'(-mag[31:0])};
			end
		end else begin
			if (mag > 64'h7fff_ffff) begin
				r = {1'b1, INT_MAX};
			end else begin
				r = {1'b0, mag[31:0]};
			end
		end
		return r;
	endfunction

endpackage

/* src/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Classifies an incoming beat and completes the simple operations.
// ----------------------------------------------------------------------------
module fpa_front #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               push,
	input  logic               full,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               wr_en,
	output fpa_pkg::item_t     item
);
	import fpa_pkg::*;

	logic signed [63:0] a64, b64, sum;
	logic [32:0]        cl;
	logic [31:0]        mag_a;
	logic [31:0]        tint;

	assign a64   = 64'(operand_a);
	assign b64   = 64'(operand_b);
	assign wr_en = push && !full;
	assign mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
	assign tint  = mag_a >> FRAC_BITS;

	always_comb begin
		item         = '0;
		item.op      = OP_SIMPLE;
		item.less    = operand_a < operand_b;
		item.equal   = operand_a == operand_b;
		item.greater = operand_a > operand_b;
		item.a_neg   = operand_a[31];
		item.neg     = operand_a[31] ^ operand_b[31];
		item.b_zero  = operand_b == 32'sd0;
		item.mag_a   = mag_a;
		item.mag_b   = operand_b[31] ? 32'(-operand_b) : operand_b;
		sum          = '0;
		case (kind)
			K_ADD:      sum = a64 + b64;
			K_SUB:      sum = a64 - b64;
			K_INC:      sum = a64 + 64'sd1;
			K_DEC:      sum = a64 - 64'sd1;
			K_FROM_INT: sum = a64 <<< FRAC_BITS;
			default:    sum = '0;
		endcase
		cl = clamp64(sum);
		unique case (kind) inside
			K_ADD, K_SUB, K_INC, K_DEC, K_FROM_INT: begin
				item.result = cl[31:0];
				item.err    = cl[32];
			end
			K_MUL:    item.op = OP_MUL;
			K_DIV:    item.op = OP_DIV;
			K_MIN:    item.result = item.less ? operand_a : operand_b;
			K_MAX:    item.result = item.greater ? operand_a : operand_b;
			K_TO_INT: item.result = operand_a[31] ? 32'(-tint) : tint;
			default:  item.result = '0;
		endcase
	end

endmodule

/* src/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fpa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  fpa_pkg::item_t wr_item,
	input  logic           rd_en,
	output fpa_pkg::item_t rd_item,
	output logic           full,
	output logic           empty
);
	import fpa_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	item_t          mem [QUEUE_DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	assign full    = cnt_q == (AW+1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_item = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en) - (AW+1)'(rd_en);
		end
	end

endmodule

/* src/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: multiplier, restoring divider one bit per stage,
// rounding and saturation, and a two-beat result buffer.
// ----------------------------------------------------------------------------
module fpa_back #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  fpa_pkg::item_t     q_item,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [31:0] result,
	output logic               less,
	output logic               equal,
	output logic               greater,
	output logic               error
);
	import fpa_pkg::*;

	localparam int NUMW = 32 + FRAC_BITS;

	typedef struct packed {
		item_t           it;
		logic [63:0]     prod;
		logic [NUMW-1:0] num;
		logic [31:0]     rem;
		logic [NUMW-1:0] quo;
	} stage_t;

	stage_t st_s   [NUMW+1];
	logic   vld_q  [NUMW+1];
	logic   adv;

	res_t        ob_mem [2];
	logic        ob_wp_q, ob_rp_q;
	logic [1:0]  ob_cnt_q;
	logic        ob_full, ob_wr;
	res_t        fin;

	assign ob_full = ob_cnt_q == 2'd2;
	assign adv     = !ob_full;
	assign q_pop   = adv && !q_empty;
	assign ob_wr   = adv && vld_q[NUMW];

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0].it   <= q_item;
			st_s[0].prod <= '0;
			st_s[0].num  <= NUMW'(q_item.mag_a) << FRAC_BITS;
			st_s[0].rem  <= '0;
			st_s[0].quo  <= '0;
		end
	end

	for (genvar i = 1; i <= NUMW; i++) begin : g_div
		logic [32:0] trial;
		logic        qb;
		assign trial = {st_s[i-1].rem, st_s[i-1].num[NUMW-1]};
		assign qb    = trial >= {1'b0, st_s[i-1].it.mag_b};
		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[i].it   <= st_s[i-1].it;
				st_s[i].prod <= (i == 1) ? 64'(st_s[0].it.mag_a) * 64'(st_s[0].it.mag_b)
				                         : st_s[i-1].prod;
				st_s[i].num  <= st_s[i-1].num << 1;
				st_s[i].rem  <= qb ? 32'(trial - {1'b0, st_s[i-1].it.mag_b}) : trial[31:0];
				st_s[i].quo  <= {st_s[i-1].quo[NUMW-2:0], qb};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUMW; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= !q_empty;
			for (int i = 1; i <= NUMW; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Rounding is to nearest with ties towards zero for both products and quotients.
	logic [63:0]   mq;
	logic [NUMW:0] dq;
	logic [32:0]   sat;
	stage_t        last;

	assign last = st_s[NUMW];

	always_comb begin
		mq = (last.prod >> FRAC_BITS) +
		     64'(last.prod[FRAC_BITS-1:0] > FRAC_BITS'(1 << (FRAC_BITS - 1)));
		dq = (NUMW+1)'(last.quo) + (NUMW+1)'({last.rem, 1'b0} > {1'b0, last.it.mag_b});
		fin.less    = last.it.less;
		fin.equal   = last.it.equal;
		fin.greater = last.it.greater;
		sat         = '0;
		case (last.it.op)
			OP_MUL:  sat = sign_sat(mq, last.it.neg);
			OP_DIV: begin
				if (last.it.b_zero) begin
					sat = {1'b1, last.it.a_neg ? INT_MIN : INT_MAX};
				end else begin
					sat = sign_sat(64'(dq), last.it.neg);
				end
			end
			default: sat = {last.it.err, last.it.result};
		endcase
		fin.result = sat[31:0];
		fin.error  = sat[32];
	end

	always_ff @(posedge clk) begin
		if (ob_wr) begin
			ob_mem[ob_wp_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wp_q  <= 1'b0;
			ob_rp_q  <= 1'b0;
			ob_cnt_q <= '0;
		end else begin
			if (ob_wr) begin
				ob_wp_q <= !ob_wp_q;
			end
			if (pop && !empty) begin
				ob_rp_q <= !ob_rp_q;
			end
			ob_cnt_q <= ob_cnt_q + 2'(ob_wr) - 2'(pop && !empty);
		end
	end

	assign empty   = ob_cnt_q == '0;
	assign result  = ob_mem[ob_rp_q].result;
	assign less    = ob_mem[ob_rp_q].less;
	assign equal   = ob_mem[ob_rp_q].equal;
	assign greater = ob_mem[ob_rp_q].greater;
	assign error   = ob_mem[ob_rp_q].error;

endmodule

/* src/fixed_point_q24_8_alu_core.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core
// Signed Q24.8 arithmetic unit with saturation and compare flags.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a beat is taken when push is high and
// full is low, carrying kind, operand_a and operand_b. Results come out of a
// queue read port: the oldest result is shown while empty is low and leaves
// when pop is high. Every beat gives exactly one result, in order.
// The front classifies the beat and finishes the simple operations; a
// four-entry queue feeds the back, whose pipeline runs one restoring divider
// stage per quotient bit. Throughput is one beat per cycle whenever the
// two-entry result buffer is not full.
// If pop is held low the two-entry result buffer fills, the back pipeline
// freezes, then the queue fills and full rises; nothing is lost.
// Reset clears all valid flags and pointers; the block is empty afterwards.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core #(
	parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [3:0]         kind,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] result,
	output logic               less,
	output logic               equal,
	output logic               greater,
	output logic               error
);
	import fpa_pkg::*;

	item_t f_item, q_item;
	logic  wr_en, q_pop, q_empty;

	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.push, .full, .kind, .operand_a, .operand_b, .wr_en, .item(f_item)
	);

	fpa_queue u_queue (
		.clk, .arst_n, .wr_en, .wr_item(f_item), .rd_en(q_pop), .rd_item(q_item),
		.full, .empty(q_empty)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .q_empty, .q_item, .q_pop, .pop, .empty,
		.result, .less, .equal, .greater, .error
	);

endmodule

/* tb/fixed_point_q24_8_alu_core_test.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core_test
// Self-checking bench for the Q24.8 arithmetic unit: directed corner beats
// and random beats are pushed with random gaps, every result beat is checked
// against an exact 64-bit model of each operation, and the reader holds off
// for a long stretch once so that the block fills and raises full.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fpa_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	typedef struct {
		logic [3:0]         kind;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} op_beat_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [3:0]         kind;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;
	logic               empty;
	logic               pop;
	logic signed [31:0] result;
	logic               less;
	logic               equal;
	logic               greater;
	logic               error;

	op_beat_t pending_ops[$];
	res_t     expected_results[$];
	int       errors;
	int       pushed;
	int       popped;
	int       saturations;
	bit       stim_done;
	bit       hold_pop;

	fixed_point_q24_8_alu_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.operand_a(operand_a), .operand_b(operand_b), .empty(empty), .pop(pop),
		.result(result), .less(less), .equal(equal), .greater(greater),
		.error(error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [63:0] sat32(input logic signed [63:0] v, inout logic err);
		if (v > 64'sd2147483647) begin
			err = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			err = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// Clip the magnitude first so that negation cannot wrap.
	function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg,
			inout logic err);
		if (m > 64'h1_0000_0000)
			m = 64'h1_0000_0000;
		return sat32(neg ? -$signed(m) : $signed(m), err);
	endfunction

	function automatic res_t alu_predict(input op_beat_t op);
		res_t r;
		logic signed [63:0] a, b, v;
		logic [63:0] p, q, rem, den;
		logic err;
		a = op.a;
		b = op.b;
		v = 0;
		err = 1'b0;
		case (op.kind)
			K_ADD: v = sat32(a + b, err);
			K_SUB: v = sat32(a - b, err);
			K_MUL: begin
				p = magnitude(a) * magnitude(b);
				q = p >> FB;
				if ((p & ((64'd1 << FB) - 1)) > (64'd1 << (FB - 1)))
					q++;
				v = apply_sign(q, (a < 0) != (b < 0), err);
			end
			K_DIV: begin
				if (b == 0) begin
					err = 1'b1;
					v = a < 0 ? -64'sd2147483648 : 64'sd2147483647;
				end else begin
					den = magnitude(b);
					p = magnitude(a) << FB;
					q = p / den;
					rem = p % den;
					if (2 * rem > den)
						q++;
					v = apply_sign(q, (a < 0) != (b < 0), err);
				end
			end
			K_MIN: v = a < b ? a : b;
			K_MAX: v = a > b ? a : b;
			K_INC: v = sat32(a + 1, err);
			K_DEC: v = sat32(a - 1, err);
			K_TO_INT: begin
				q = magnitude(a) >> FB;
				v = a < 0 ? -$signed(q) : $signed(q);
			end
			K_FROM_INT: v = sat32(a * (64'sd1 << FB), err);
			default: v = 0;
		endcase
		r.result = v[31:0];
		r.less = a < b;
		r.equal = a == b;
		r.greater = a > b;
		r.error = err;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff - $urandom_range(0, 3);
			1: return 32'sh8000_0000 + $urandom_range(0, 3);
			2: return $signed(32'($urandom_range(0, 1024))) - 512;
			3: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(input logic [3:0] k, input logic signed [31:0] a,
			input logic signed [31:0] b);
		op_beat_t op;
		op.kind = k;
		op.a = a;
		op.b = b;
		pending_ops.push_back(op);
	endtask

	initial begin
		logic signed [31:0] ra, rb;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		kind = '0;
		operand_a = '0;
		operand_b = '0;
		errors = 0;
		pushed = 0;
		popped = 0;
		saturations = 0;
		stim_done = 1'b0;
		hold_pop = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Corners: overflow each way, exact ties, division by zero, unused kinds.
		add_op(K_ADD, 32'sh7fff_ffff, 32'sd1);
		add_op(K_SUB, 32'sh8000_0000, 32'sd1);
		add_op(K_MUL, 32'sh8000_0000, 32'sh8000_0000);
		add_op(K_MUL, 32'sh8000_0000, 32'sd256);
		add_op(K_MUL, 32'sd384, -32'sd128);
		add_op(K_MUL, 32'sd3, 32'sd128);
		add_op(K_DIV, 32'sd256, 32'sd0);
		add_op(K_DIV, -32'sd1, 32'sd0);
		add_op(K_DIV, 32'sh8000_0000, -32'sd256);
		add_op(K_DIV, 32'sd1, 32'sd512);
		add_op(K_DIV, -32'sd3, 32'sd512);
		add_op(K_MIN, 32'sh8000_0000, 32'sh7fff_ffff);
		add_op(K_MAX, 32'sh8000_0000, 32'sh7fff_ffff);
		add_op(K_COMPARE, 32'sd5, 32'sd5);
		add_op(K_INC, 32'sh7fff_ffff, 32'sd0);
		add_op(K_DEC, 32'sh8000_0000, 32'sd0);
		add_op(K_TO_INT, -32'sd255, 32'sd0);
		add_op(K_TO_INT, 32'sh8000_0000, 32'sd0);
		add_op(K_FROM_INT, 32'sh0080_0000, 32'sd0);
		add_op(K_FROM_INT, -32'sh0080_0001, 32'sd0);
		add_op(4'd11, -32'sd1, 32'sd7);
		add_op(4'd15, 32'sh7fff_ffff, 32'sh8000_0000);
		for (int i = 0; i < 600; i++) begin
			ra = rand_operand();
			rb = ($urandom_range(0, 15) == 0) ? ra : rand_operand();
			add_op($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 10)) : 4'($urandom),
				ra, rb);
		end
		wait (pending_ops.size() == 0 && !push);
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
		$display("Checked %0d beats over all kinds, %0d of them saturating or dividing by zero.",
			popped, saturations);
		$display("Random gaps on both sides, with one long read stall that filled the block.");
		if (errors == 0 && pushed == popped)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Sender: random gaps, mostly short.
	int send_gap;
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				expected_results.push_back(alu_predict('{kind, operand_a, operand_b}));
				pushed++;
			end
			if (!push || !full) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					push <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op_beat_t op;
					op = pending_ops.pop_front();
					push <= 1'b1;
					kind <= op.kind;
					operand_a <= op.a;
					operand_b <= op.b;
					send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
						($urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
				end else begin
					push <= 1'b0;
				end
			end
		end else begin
			send_gap <= 0;
		end
	end

	// One long read stall once the random part is under way.
	initial begin
		wait (pushed >= 60);
		hold_pop = 1'b1;
		repeat (200) @(posedge clk);
		hold_pop = 1'b0;
	end

	// Receiver and checker.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				res_t exp_r;
				popped++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.error)
						saturations++;
					if (result !== exp_r.result) begin
						$error("result: expected %0d, got %0d", $signed(exp_r.result), result);
						errors++;
					end
					if (less !== exp_r.less) begin
						$error("less: expected %0b, got %0b", exp_r.less, less);
						errors++;
					end
					if (equal !== exp_r.equal) begin
						$error("equal: expected %0b, got %0b", exp_r.equal, equal);
						errors++;
					end
					if (greater !== exp_r.greater) begin
						$error("greater: expected %0b, got %0b", exp_r.greater, greater);
						errors++;
					end
					if (error !== exp_r.error) begin
						$error("error: expected %0b, got %0b", exp_r.error, error);
						errors++;
					end
				end
			end
			pop <= !hold_pop && ($urandom_range(0, 9) < 7 ||
				($urandom_range(0, 29) == 0 ? 1'b0 : 1'b1) && $urandom_range(0, 1));
		end
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
